// ===== hdl/pldr_pkg.sv =====
`default_nettype none
package pldr_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN = 24;
  localparam logic [30:0] MAX_ACCEL_RST = 31'd655360;
  localparam logic CMD_ADVANCE = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef struct packed {
    logic               command;
    logic signed [31:0] target_speed;
    logic signed [31:0] turn_rate;
    logic [15:0]        step_time;
    logic [15:0]        load_heading;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
    logic signed [31:0] load_vx;
    logic signed [31:0] load_vy;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        heading;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_HEAD, ST_SQX, ST_SQY, ST_LIM, ST_ROOT_INIT, ST_ROOT,
    ST_SPEED, ST_MUL_C, ST_MUL_S, ST_POS_X, ST_POS_Y, ST_WB, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MUL_RATE_DT, MUL_VX_SQ, MUL_VY_SQ, MUL_ACC_DT,
    MUL_SPD_C, MUL_SPD_S, MUL_VX_DT, MUL_VY_DT
  } mul_sel_t;

  typedef struct packed {
    logic     take_in;
    logic     load;
    mul_sel_t mul_sel;
    logic     take_head;
    logic     take_sqx;
    logic     take_sqy;
    logic     take_lim;
    logic     root_start;
    logic     root_step;
    logic     cordic_start;
    logic     take_speed;
    logic     take_velx;
    logic     take_vely;
    logic     take_posx;
    logic     take_posy;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic root_done;
    logic cordic_done;
  } dp_stat_t;

  // arctan(2^-i), 2^32 units per turn
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // magnitude of (2^28, 0) after a zero-angle rotation, elaboration only
  function automatic longint unsigned cordic_gain(input int steps);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    longint unsigned n;
    longint unsigned res;
    longint unsigned bitv;
    x = longint'(1) <<< 28;
    y = 0;
    z = 0;
    for (int i = 0; i < steps && i < ATAN_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(atan_entry(5'(i)));
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(atan_entry(5'(i)));
      end
    end
    n = longint'(x * x) + longint'(y * y);
    res = 0;
    bitv = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // shift right rounding half away from zero
  function automatic logic signed [69:0] rnd_shift(input logic signed [69:0] v,
                                                   input int sh);
    logic [69:0] mag;
    logic [69:0] r;
    mag = v[69] ? 70'(-v) : 70'(v);
    r = (mag + (70'(1) << (sh - 1))) >> sh;
    return v[69] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
    logic signed [31:0] r;
    if (v > 70'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -70'sd2147483648) r = 32'sh80000000;
    else r = $signed(v[31:0]);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/pldr_if.sv =====
`default_nettype none
interface pldr_in_if;
  logic              valid;
  logic              ready;
  pldr_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface pldr_out_if;
  logic               valid;
  logic               ready;
  pldr_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/pldr_ctrl.sv =====
`default_nettype none
module pldr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_command,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pldr_pkg::dp_cmd_t      cmd,
  input  wire pldr_pkg::dp_stat_t stat
);
  import pldr_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.mul_sel   = MUL_RATE_DT;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          if (in_command == CMD_LOAD) begin
            cmd.load  = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_HEAD;
          end
        end
      end
      ST_HEAD: begin
        cmd.mul_sel = MUL_RATE_DT;
        state_nxt   = ST_SQX;
      end
      ST_SQX: begin
        cmd.take_head = 1'b1;
        cmd.mul_sel   = MUL_VX_SQ;
        state_nxt     = ST_SQY;
      end
      ST_SQY: begin
        // heading is final here, so sine and cosine start here and run alongside the root
        cmd.take_sqx     = 1'b1;
        cmd.cordic_start = 1'b1;
        cmd.mul_sel      = MUL_VY_SQ;
        state_nxt        = ST_LIM;
      end
      ST_LIM: begin
        cmd.take_sqy = 1'b1;
        cmd.mul_sel  = MUL_ACC_DT;
        state_nxt    = ST_ROOT_INIT;
      end
      ST_ROOT_INIT: begin
        cmd.take_lim   = 1'b1;
        cmd.root_start = 1'b1;
        state_nxt      = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (stat.root_done && stat.cordic_done) state_nxt = ST_SPEED;
      end
      ST_SPEED: begin
        cmd.take_speed = 1'b1;
        state_nxt      = ST_MUL_C;
      end
      ST_MUL_C: begin
        cmd.mul_sel = MUL_SPD_C;
        state_nxt   = ST_MUL_S;
      end
      ST_MUL_S: begin
        cmd.take_velx = 1'b1;
        cmd.mul_sel   = MUL_SPD_S;
        state_nxt     = ST_POS_X;
      end
      ST_POS_X: begin
        cmd.take_vely = 1'b1;
        cmd.mul_sel   = MUL_VX_DT;
        state_nxt     = ST_POS_Y;
      end
      ST_POS_Y: begin
        cmd.take_posx = 1'b1;
        cmd.mul_sel   = MUL_VY_DT;
        state_nxt     = ST_WB;
      end
      ST_WB: begin
        cmd.take_posy = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        // result slot frees up once the previous beat is taken
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== hdl/pldr_dp.sv =====
`default_nettype none
module pldr_dp #(
  parameter int CORDIC_STEPS = pldr_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pldr_pkg::in_item_t  in_data,
  input  wire logic                cfg_we,
  input  wire logic [30:0]         cfg_data,
  input  wire pldr_pkg::dp_cmd_t   cmd,
  output pldr_pkg::dp_stat_t       stat,
  output pldr_pkg::out_item_t      out_data
);
  import pldr_pkg::*;

  localparam int IW = $clog2(CORDIC_STEPS + 1);
  localparam longint unsigned GAIN = cordic_gain(CORDIC_STEPS);
  localparam longint unsigned START = ((64'd1 << 56) + GAIN / 2) / GAIN;

  logic [30:0]        accel_r;
  in_item_t           in_r;
  logic [15:0]        head_r;
  logic signed [31:0] posx_r, posy_r, velx_r, vely_r;
  logic signed [69:0] prod_r;
  logic [63:0]        sq_r;
  logic [30:0]        lim_r;
  logic [63:0]        n_r, res_r, bit_r;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic [IW-1:0]      iter_r;
  logic               flip_r;
  logic signed [34:0] spd2_r;
  out_item_t          out_r;

  logic signed [34:0] mul_a, mul_b;
  logic signed [69:0] mul_p;
  logic signed [33:0] cos_v, sin_v;
  logic [31:0]        hsum;
  logic signed [33:0] ang, ang_adj;
  logic               ang_flip;
  logic [4:0]         sh;
  logic signed [33:0] xs, ys, atan_v;
  logic [63:0]        trial;
  logic signed [34:0] tgt35, spd35, lim35, dv, dvc;
  logic               cordic_busy;

  assign cos_v = flip_r ? -cx_r : cx_r;
  assign sin_v = flip_r ? -cy_r : cy_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MUL_RATE_DT: begin
        mul_a = 35'(in_r.turn_rate);
        mul_b = $signed({19'd0, in_r.step_time});
      end
      MUL_VX_SQ: begin
        mul_a = 35'(velx_r);
        mul_b = 35'(velx_r);
      end
      MUL_VY_SQ: begin
        mul_a = 35'(vely_r);
        mul_b = 35'(vely_r);
      end
      MUL_ACC_DT: begin
        mul_a = $signed({4'd0, accel_r});
        mul_b = $signed({19'd0, in_r.step_time});
      end
      MUL_SPD_C: begin
        mul_a = spd2_r;
        mul_b = 35'(cos_v);
      end
      MUL_SPD_S: begin
        mul_a = spd2_r;
        mul_b = 35'(sin_v);
      end
      MUL_VX_DT: begin
        mul_a = 35'(velx_r);
        mul_b = $signed({19'd0, in_r.step_time});
      end
      MUL_VY_DT: begin
        mul_a = 35'(vely_r);
        mul_b = $signed({19'd0, in_r.step_time});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign hsum  = prod_r[31:0] + 32'h8000;

  // fold the heading into the right half plane
  always_comb begin
    ang      = $signed({{2{head_r[15]}}, head_r, 16'd0});
    ang_adj  = ang;
    ang_flip = 1'b0;
    if (ang > 34'sd1073741824) begin
      ang_adj  = ang - 34'sd2147483648;
      ang_flip = 1'b1;
    end else if (ang < -34'sd1073741824) begin
      ang_adj  = ang + 34'sd2147483648;
      ang_flip = 1'b1;
    end
  end

  assign cordic_busy = (iter_r != IW'(CORDIC_STEPS));
  assign sh     = 5'(iter_r);
  assign xs     = cx_r >>> sh;
  assign ys     = cy_r >>> sh;
  assign atan_v = $signed({2'b00, atan_entry(sh)});
  assign trial  = res_r + bit_r;

  always_comb begin
    tgt35 = 35'(in_r.target_speed);
    spd35 = $signed({3'b000, res_r[31:0]});
    lim35 = $signed({4'd0, lim_r});
    dv    = tgt35 - spd35;
    dvc   = dv;
    if (dv > lim35) dvc = lim35;
    else if (dv < -lim35) dvc = -lim35;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r <= MAX_ACCEL_RST;
      head_r  <= '0;
      posx_r  <= '0;
      posy_r  <= '0;
      velx_r  <= '0;
      vely_r  <= '0;
      iter_r  <= IW'(CORDIC_STEPS);
    end else begin
      if (cfg_we) accel_r <= cfg_data;
      if (cmd.load) begin
        head_r <= in_data.load_heading;
        posx_r <= in_data.load_x;
        posy_r <= in_data.load_y;
        velx_r <= in_data.load_vx;
        vely_r <= in_data.load_vy;
      end
      if (cmd.take_head) head_r <= head_r + hsum[31:16];
      if (cmd.take_velx) velx_r <= sat32(rnd_shift(prod_r, 28));
      if (cmd.take_vely) vely_r <= sat32(rnd_shift(prod_r, 28));
      if (cmd.take_posx) posx_r <= sat32(70'(posx_r) + rnd_shift(prod_r, 16));
      if (cmd.take_posy) posy_r <= sat32(70'(posy_r) + rnd_shift(prod_r, 16));
      if (cmd.cordic_start) iter_r <= '0;
      else if (cordic_busy) iter_r <= iter_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (cmd.take_in) in_r <= in_data;
    if (cmd.take_sqx) sq_r <= prod_r[63:0];
    if (cmd.take_sqy) sq_r <= sq_r + prod_r[63:0];
    if (cmd.take_lim) lim_r <= prod_r[46:16];
    if (cmd.root_start) begin
      n_r   <= sq_r;
      res_r <= '0;
      bit_r <= 64'd1 << 62;
    end else if (cmd.root_step && bit_r != '0) begin
      if (n_r >= trial) begin
        n_r   <= n_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.cordic_start) begin
      cx_r   <= 34'(START);
      cy_r   <= '0;
      cz_r   <= ang_adj;
      flip_r <= ang_flip;
    end else if (cordic_busy) begin
      if (cz_r >= 0) begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - atan_v;
      end else begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + atan_v;
      end
    end
    if (cmd.take_speed) spd2_r <= spd35 + dvc;
    if (cmd.out_load) begin
      out_r.heading <= head_r;
      out_r.pos_x   <= posx_r;
      out_r.pos_y   <= posy_r;
      out_r.vel_x   <= velx_r;
      out_r.vel_y   <= vely_r;
    end
  end

  assign stat.root_done   = (bit_r == '0);
  assign stat.cordic_done = !cordic_busy;
  assign out_data         = out_r;

endmodule
`default_nettype wire

// ===== hdl/planar_speed_limited_dead_reckoning.sv =====
// Planar dead reckoning: each beat on in_ch either loads heading, position and
// velocity or advances them by one time step (turn, speed limited by cfg_data
// times the step, velocity re-aimed along the heading, Euler position update),
// and one beat with the new state follows on out_ch. Items are taken one at a
// time; a load goes straight to the result stage, while an advance waits for
// the 32-iteration square root of the speed, which runs alongside a
// CORDIC_STEPS-iteration CORDIC for sine and cosine, and makes eight passes
// through one shared 35x35 multiplier. A finished result waits in an output
// register, so the next item is accepted while it is still pending; a second
// finished result waits until it is taken.
// Write cfg_data only while no item is in flight.
`default_nettype none
module planar_speed_limited_dead_reckoning #(
  parameter int CORDIC_STEPS = pldr_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  pldr_in_if.sink          in_ch,
  pldr_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [30:0] cfg_data
);
  import pldr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pldr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.data.command),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .cmd        (cmd),
    .stat       (stat)
  );

  pldr_dp #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_ch.data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_ch.data)
  );

endmodule
`default_nettype wire

// ===== hdl/pldr_checker.sv =====
`default_nettype none
module pldr_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                in_command,
  input wire logic signed [31:0]  in_load_x,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire pldr_pkg::out_item_t out_data
);
  import pldr_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while busy");

  // a load with a free result slot comes back with its x position unchanged
  a_load_echo: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_LOAD && !out_valid
    |=> ##1 out_valid && out_data.pos_x == $past(in_load_x, 2))
    else $error("loaded position not returned");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind planar_speed_limited_dead_reckoning pldr_checker u_pldr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_command (in_ch.data.command),
  .in_load_x  (in_ch.data.load_x),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_data   (out_ch.data)
);
`default_nettype wire

// ===== bench/pldr_checker.sv =====
`default_nettype none
module pldr_tb_checker #(
  parameter int STEPS = pldr_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  pldr_in_if               in_mon,
  pldr_out_if              out_mon,
  input  wire logic        cfg_we,
  input  wire logic [30:0] cfg_data,
  output int               fail_cnt,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pldr_pkg::*;

  logic [30:0]        accel_lim;
  logic [15:0]        head_st;
  logic signed [31:0] px_st, py_st, vx_st, vy_st;
  out_item_t          state_q[$];
  longint             start_vec;

  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic rotate(input longint x0, input longint ang, output longint cx,
                        output longint sy);
    longint x, y, z, xs, ys;
    x = x0;
    y = 0;
    z = ang;
    for (int i = 0; i < STEPS && i < ATAN_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - longint'(atan_entry(5'(i)));
      end else begin
        x = x + ys; y = y - xs; z = z + longint'(atan_entry(5'(i)));
      end
    end
    cx = x;
    sy = y;
  endtask

  function automatic longint round_shift(input longint v, input int sh);
    longint half;
    half = longint'(1) << (sh - 1);
    if (v >= 0) return (v + half) >>> sh;
    return -((-v + half) >>> sh);
  endfunction

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  initial begin
    longint gx, gy;
    longint unsigned g;
    rotate(longint'(1) << 28, 0, gx, gy);
    g = root_floor(longint'(gx * gx) + longint'(gy * gy));
    if (g == 0) g = 1;
    start_vec = longint'(((64'd1 << 56) + g / 2) / g);
    fail_cnt = 0;
  end

  task automatic advance_state(input in_item_t it);
    longint rate, dt, dh, spd, lim, dv, spd2, a, c, s;
    longint unsigned sq;
    bit flip;
    rate = it.turn_rate;
    dt = longint'({48'd0, it.step_time});
    dh = (rate * dt + 64'sh8000) >>> 16;
    head_st = head_st + dh[15:0];
    sq = longint'(longint'(vx_st) * vx_st) + longint'(longint'(vy_st) * vy_st);
    spd = longint'(root_floor(sq));
    lim = longint'((longint'({33'd0, accel_lim}) * dt) >>> 16);
    dv = longint'(it.target_speed) - spd;
    if (dv > lim) dv = lim;
    if (dv < -lim) dv = -lim;
    spd2 = spd + dv;
    a = longint'({48'd0, head_st}) << 16;
    flip = 0;
    if (a >= (longint'(1) << 31)) a = a - (longint'(1) << 32);
    if (a > (longint'(1) << 30)) begin
      a = a - (longint'(1) << 31); flip = 1;
    end else if (a < -(longint'(1) << 30)) begin
      a = a + (longint'(1) << 31); flip = 1;
    end
    rotate(start_vec, a, c, s);
    if (flip) begin
      c = -c; s = -s;
    end
    vx_st = clip32(round_shift(spd2 * c, 28));
    vy_st = clip32(round_shift(spd2 * s, 28));
    px_st = clip32(longint'(px_st) + round_shift(longint'(vx_st) * dt, 16));
    py_st = clip32(longint'(py_st) + round_shift(longint'(vy_st) * dt, 16));
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    fail_cnt++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      accel_lim = MAX_ACCEL_RST;
      head_st = 0; px_st = 0; py_st = 0; vx_st = 0; vy_st = 0;
      state_q.delete();
    end else begin
      if (cfg_we) accel_lim = cfg_data;
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.data.command == CMD_LOAD) begin
          head_st = in_mon.data.load_heading;
          px_st = in_mon.data.load_x;
          py_st = in_mon.data.load_y;
          vx_st = in_mon.data.load_vx;
          vy_st = in_mon.data.load_vy;
        end else begin
          advance_state(in_mon.data);
        end
        state_q.push_back('{head_st, px_st, py_st, vx_st, vy_st});
      end
      if (out_mon.valid && out_mon.ready) begin
        if (state_q.size() == 0) begin
          $display("%0t unexpected result beat", $realtime);
          fail_cnt++;
        end else begin
          want = state_q.pop_front();
          if (out_mon.data.heading !== want.heading)
            report("heading", out_mon.data.heading, want.heading);
          if (out_mon.data.pos_x !== want.pos_x)
            report("pos_x", out_mon.data.pos_x, want.pos_x);
          if (out_mon.data.pos_y !== want.pos_y)
            report("pos_y", out_mon.data.pos_y, want.pos_y);
          if (out_mon.data.vel_x !== want.vel_x)
            report("vel_x", out_mon.data.vel_x, want.vel_x);
          if (out_mon.data.vel_y !== want.vel_y)
            report("vel_y", out_mon.data.vel_y, want.vel_y);
        end
      end
    end
    pending = state_q.size();
  end
endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pldr_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [30:0] cfg_data;
  int          fail_cnt, pending;
  int          send_idle, recv_idle;
  bit          hold_req;
  int          n_load, n_adv;

  pldr_in_if  in_ch();
  pldr_out_if out_ch();

  planar_speed_limited_dead_reckoning i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  pldr_tb_checker i_chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .fail_cnt(fail_cnt), .pending(pending)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("FAIL planar_speed_limited_dead_reckoning");
        $finish;
      end
    end
  end

  // result side, with a single long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send(input in_item_t it);
    forever begin
      @(negedge clk);
      if ($urandom_range(99) < send_idle) begin
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        break;
      end
    end
    do @(posedge clk); while (!in_ch.ready);
    if (it.command == CMD_LOAD) n_load++;
    else n_adv++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_accel(input logic [30:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t load_item(input logic [15:0] h, input int x, input int y,
                                         input int vx, input int vy);
    in_item_t it;
    it = '{default: '0};
    it.command = CMD_LOAD;
    it.target_speed = $urandom;
    it.turn_rate = $urandom;
    it.step_time = 16'($urandom);
    it.load_heading = h;
    it.load_x = x; it.load_y = y; it.load_vx = vx; it.load_vy = vy;
    return it;
  endfunction

  function automatic in_item_t step_item(input int tgt, input int rate,
                                         input logic [15:0] dt);
    in_item_t it;
    it = '{default: '0};
    it.command = CMD_ADVANCE;
    it.target_speed = tgt;
    it.turn_rate = rate;
    it.step_time = dt;
    it.load_heading = 16'($urandom);
    it.load_x = $urandom; it.load_y = $urandom;
    it.load_vx = $urandom; it.load_vy = $urandom;
    return it;
  endfunction

  function automatic int mixed_val();
    case ($urandom_range(3))
      0: return $urandom;
      1: return int'($urandom_range(20 << 16)) - (10 << 16);
      2: return int'($urandom_range(2000 << 16)) - (1000 << 16);
      default: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
    endcase
  endfunction

  function automatic in_item_t random_item();
    logic [15:0] dt;
    if ($urandom_range(99) < 20)
      return load_item(16'($urandom), mixed_val(), mixed_val(), mixed_val(), mixed_val());
    dt = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(6554));
    if ($urandom_range(19) == 0) dt = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    return step_item(mixed_val(), $urandom_range(1) ? int'($urandom) :
                     int'($urandom_range(131072)) - 65536, dt);
  endfunction

  initial begin
    logic [30:0] accel_set[3];
    accel_set[0] = 31'h7FFFFFFF;
    accel_set[1] = 31'd0;
    accel_set[2] = 31'($urandom);
    n_load = 0;
    n_adv = 0;
    hold_req = 0;
    send_idle = 29;
    recv_idle = 46;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: default accel first
    send(step_item(32'sh7FFFFFFF, 65536, 16'hFFFF));
    send(step_item(32'sh80000000, -65536, 16'hFFFF));
    send(step_item(5 << 16, 32'sh7FFFFFFF, 16'hFFFF));
    send(step_item(5 << 16, 32'sh80000000, 16'hFFFF));
    send(step_item(3 << 16, 1000, 16'h0000));
    send(load_item(16'd16384, 0, 0, 10 << 16, 0));
    send(step_item(10 << 16, 0, 16'd6554));
    send(load_item(16'd16385, 0, 0, 0, 10 << 16));
    send(step_item(10 << 16, 0, 16'd6554));
    send(load_item(16'd32768, 0, 0, -(10 << 16), 0));
    send(step_item(-(10 << 16), 0, 16'd6554));
    send(load_item(16'd49152, 0, 0, 0, 0));
    send(step_item(0, 0, 16'd1));
    send(load_item(16'hFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                   32'sh7FFFFFFF));
    send(step_item(32'sh7FFFFFFF, 0, 16'hFFFF));
    send(load_item(16'h0000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                   32'sh80000000));
    send(step_item(32'sh80000000, 0, 16'hFFFF));
    send(load_item(16'd8192, 32'sh7FFFFF00, 32'sh7FFFFF00, 32'sh7FFFFFFF, 0));
    send(step_item(32'sh7FFFFFFF, 0, 16'hFFFF));

    for (int ph = 0; ph < 3; ph++) begin
      write_accel(accel_set[ph]);
      if (ph == 1) begin
        send_idle = 46; recv_idle = 29;
      end else if (ph == 2) begin
        send_idle = 0; recv_idle = 0;
      end
      for (int k = 0; k < 127; k++) begin
        if (ph == 2 && k == 40) hold_req = 1;
        if (k == 80) drain();
        send(random_item());
      end
    end
    write_accel(MAX_ACCEL_RST);
    for (int k = 0; k < 6; k++) send(random_item());

    drain();
    $display("covered %0d loads and %0d steps over four accel limits (max, 0, random, reset)",
             n_load, n_adv);
    $display("with sender/receiver idling, a long result hold-off and drained pauses");
    if (fail_cnt == 0 && pending == 0) begin
      $display("PASS planar_speed_limited_dead_reckoning");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_cnt, pending);
      $display("FAIL planar_speed_limited_dead_reckoning");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== planar_speed_limited_dead_reckoning.f =====
hdl/pldr_pkg.sv
hdl/pldr_if.sv
hdl/pldr_ctrl.sv
hdl/pldr_dp.sv
hdl/planar_speed_limited_dead_reckoning.sv
hdl/pldr_checker.sv
bench/pldr_checker.sv
bench/tb.sv
